FILE: src/ypc_pkg.sv
// Package for the yaw/pitch camera block: fixed-point constants, CORDIC table, command types.
// No dependencies.
package ypc_pkg;

	localparam int ATAN_N = 24;
	localparam logic signed [16:0] DEG90 = 17'sd23040;
	localparam logic signed [17:0] DEG180 = 18'sd46080;
	localparam logic signed [18:0] DEG360 = 19'sd92160;
	localparam logic signed [15:0] PITCH_LIM = 16'sd22784;
	localparam logic signed [15:0] ONE14 = 16'sd16384;
	localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
	localparam logic signed [16:0] HEAD_HOME = -17'sd23040;

	localparam logic [1:0] OP_MOVE = 2'd0;
	localparam logic [1:0] OP_TURN = 2'd1;
	localparam logic [1:0] OP_HOME = 2'd2;

	localparam logic [2:0] KEY_FWD = 3'd0;
	localparam logic [2:0] KEY_BACK = 3'd1;
	localparam logic [2:0] KEY_LEFT = 3'd2;
	localparam logic [2:0] KEY_RIGHT = 3'd3;

	localparam logic [2:0] REG_SPEED = 3'd0;
	localparam logic [2:0] REG_GAIN = 3'd1;
	localparam logic [2:0] REG_SX = 3'd2;
	localparam logic [2:0] REG_SY = 3'd3;
	localparam logic [2:0] REG_SZ = 3'd4;

	function automatic logic [21:0] atan_deg16(input logic [4:0] i);
		case (i)
			5'd0: atan_deg16 = 22'd2949120;
			5'd1: atan_deg16 = 22'd1740967;
			5'd2: atan_deg16 = 22'd919879;
			5'd3: atan_deg16 = 22'd466945;
			5'd4: atan_deg16 = 22'd234379;
			5'd5: atan_deg16 = 22'd117304;
			5'd6: atan_deg16 = 22'd58666;
			5'd7: atan_deg16 = 22'd29335;
			5'd8: atan_deg16 = 22'd14668;
			5'd9: atan_deg16 = 22'd7334;
			5'd10: atan_deg16 = 22'd3667;
			5'd11: atan_deg16 = 22'd1833;
			5'd12: atan_deg16 = 22'd917;
			5'd13: atan_deg16 = 22'd458;
			5'd14: atan_deg16 = 22'd229;
			5'd15: atan_deg16 = 22'd115;
			5'd16: atan_deg16 = 22'd57;
			5'd17: atan_deg16 = 22'd29;
			5'd18: atan_deg16 = 22'd14;
			5'd19: atan_deg16 = 22'd7;
			5'd20: atan_deg16 = 22'd4;
			5'd21: atan_deg16 = 22'd2;
			5'd22: atan_deg16 = 22'd1;
			default: atan_deg16 = 22'd0;
		endcase
	endfunction

	// Datapath commands issued by the controller.
	typedef enum logic [3:0] {
		CMD_NONE  = 4'd0,
		CMD_LOAD  = 4'd1,  // capture item, compute velocity and angle steps
		CMD_ANGLE = 4'd2,  // apply steps, wrap yaw, clamp pitch
		CMD_CINIT = 4'd3,  // load CORDIC with yaw or pitch
		CMD_CITER = 4'd4,  // one CORDIC micro-rotation
		CMD_CDONE = 4'd5,  // round and store cos/sin
		CMD_PROD  = 4'd6,  // one basis product
		CMD_MSTEP = 4'd7,  // one movement product
		CMD_MACC  = 4'd8,  // store one basis product or accumulate one position component
		CMD_HOME  = 4'd9,
		CMD_OUT   = 4'd10  // latch the result
	} ypc_cmd_e_t;

	typedef struct packed {
		ypc_cmd_e_t cmd;
		logic       sel;    // CORDIC: 0 yaw, 1 pitch
		logic [4:0] idx;    // iteration or component index
	} ypc_ctrl_t;

	typedef struct packed {
		logic [1:0] op;
		logic [2:0] key;
	} ypc_stat_t;

endpackage

FILE: src/ypc_if.sv
// Valid/ready channel interface carrying a generic payload.
// Depends on nothing.
interface ypc_if #(parameter int W = 8) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/ypc_dp.sv
// Datapath for the camera block: angle update, shared CORDIC, shared multiplier, position.
// Depends on ypc_pkg.
module ypc_dp #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ypc_pkg::ypc_ctrl_t ctrl,
	output ypc_pkg::ypc_stat_t stat,
	input  logic [1:0]         in_op,
	input  logic [2:0]         in_key,
	input  logic [15:0]        in_dt,
	input  logic signed [23:0] in_xo,
	input  logic signed [23:0] in_yo,
	input  logic [15:0]        move_speed,
	input  logic [15:0]        mouse_gain,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [31:0] start_z,
	output logic [223:0]       result
);
	import ypc_pkg::*;

	logic [1:0] op_q;
	logic [2:0] key_q;
	logic [31:0] vel_q;
	logic signed [40:0] hstep_q, pstep_q;
	logic signed [25:0] hv_q;
	logic signed [31:0] pos_q [3];
	logic signed [16:0] head_q;
	logic signed [15:0] elev_q;
	logic signed [15:0] bas_q [8];
	logic signed [15:0] cy_q, sy_q, cp_q, sp_q;
	logic signed [33:0] cx_q, cyv_q;
	logic signed [24:0] cz_q;
	logic flip_q;
	logic signed [48:0] prod_q;

	// angle update: hv_q holds yaw + step + 180 + 92*360, always non-negative.
	// Reduce it modulo 360 (= 45 * 2^11): the low 11 bits pass, the upper part
	// is reduced modulo 45 by a reciprocal multiply and one compare-subtract.
	logic [13:0] hu, hr0, hr;
	logic [24:0] hq_full;
	logic [7:0] hq;
	logic signed [18:0] h_wr;
	logic signed [25:0] p_new, p_cl;
	always_comb begin
		hu = hv_q[24:11];
		hq_full = 25'(hu) * 25'd1456;
		hq = hq_full[23:16];
		hr0 = hu - 14'(hq) * 14'd45;
		hr = (hr0 >= 14'd45) ? hr0 - 14'd45 : hr0;
		h_wr = $signed({2'b00, hr[5:0], hv_q[10:0]});
		p_new = 26'(elev_q) + 26'($signed(pstep_q[40:16]));
		if (p_new > 26'(PITCH_LIM))
			p_cl = 26'(PITCH_LIM);
		else if (p_new < -26'(PITCH_LIM))
			p_cl = -26'(PITCH_LIM);
		else
			p_cl = p_new;
	end

	// CORDIC setup and step
	logic signed [17:0] ang, afold;
	logic signed [33:0] dx, dy;
	logic signed [17:0] cos_r, sin_r;
	logic signed [15:0] cos_c, sin_c;
	always_comb begin
		ang = ctrl.sel ? 18'(elev_q) : 18'(head_q);
		afold = ang;
		if (ang > 18'(DEG90))
			afold = ang - DEG180;
		else if (ang < -18'(DEG90))
			afold = ang + DEG180;
		dx = cyv_q >>> ctrl.idx;
		dy = cx_q >>> ctrl.idx;
		cos_r = 18'((cx_q + 34'sd32768) >>> 16);
		sin_r = 18'((cyv_q + 34'sd32768) >>> 16);
		cos_c = (cos_r > 18'(ONE14)) ? ONE14 : (cos_r < -18'(ONE14)) ? -ONE14 : 16'(cos_r);
		sin_c = (sin_r > 18'(ONE14)) ? ONE14 : (sin_r < -18'(ONE14)) ? -ONE14 : 16'(sin_r);
		if (flip_q) begin
			cos_c = -cos_c;
			sin_c = -sin_c;
		end
	end

	// shared multiplier operand selection
	logic signed [32:0] ma, mb;
	logic signed [15:0] vc;
	always_comb begin
		vc = '0;
		case (ctrl.idx[1:0])
			2'd0: vc = (key_q[1]) ? bas_q[3] : bas_q[0];
			2'd1: vc = (key_q[1]) ? 16'sd0 : bas_q[1];
			default: vc = (key_q[1]) ? bas_q[4] : bas_q[2];
		endcase
		ma = 33'(cy_q);
		mb = 33'(cp_q);
		case (ctrl.idx[1:0])
			2'd0: begin ma = 33'(cy_q); mb = 33'(cp_q); end
			2'd1: begin ma = 33'(sy_q); mb = 33'(cp_q); end
			2'd2: begin ma = 33'(cy_q); mb = 33'(sp_q); end
			default: begin ma = 33'(sy_q); mb = 33'(sp_q); end
		endcase
		if (ctrl.cmd == CMD_MSTEP) begin
			ma = $signed({1'b0, vel_q});
			mb = 33'(vc);
		end
	end
	logic signed [65:0] mfull;
	assign mfull = ma * mb;

	logic signed [17:0] p14r;
	logic signed [15:0] p14;
	logic signed [27:0] stp;
	logic signed [33:0] psum;
	logic signed [31:0] psat;
	logic neg;
	always_comb begin
		p14r = 18'((prod_q + 49'sd8192) >>> 14);
		p14 = (p14r > 18'(ONE14)) ? ONE14 : (p14r < -18'(ONE14)) ? -ONE14 : 16'(p14r);
		stp = 28'((prod_q + 49'sd2097152) >>> 22);
		neg = (key_q == KEY_BACK) || (key_q == KEY_LEFT);
		psum = neg ? 34'(pos_q[ctrl.idx[1:0]]) - 34'(stp)
		           : 34'(pos_q[ctrl.idx[1:0]]) + 34'(stp);
		if (psum > 34'sd2147483647)
			psat = 32'sh7fffffff;
		else if (psum < -34'sd2147483648)
			psat = 32'sh80000000;
		else
			psat = 32'(psum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
			head_q <= HEAD_HOME;
			elev_q <= '0;
			bas_q[0] <= '0; bas_q[1] <= '0; bas_q[2] <= -ONE14; bas_q[3] <= ONE14;
			bas_q[4] <= '0; bas_q[5] <= '0; bas_q[6] <= ONE14; bas_q[7] <= '0;
		end else begin
			case (ctrl.cmd)
				CMD_ANGLE: begin
					head_q <= 17'(h_wr - 19'(DEG180));
					elev_q <= 16'(p_cl);
				end
				CMD_CDONE: begin
					if (ctrl.sel) begin
						bas_q[1] <= sin_c; bas_q[6] <= cos_c;
					end else begin
						bas_q[3] <= -sin_c; bas_q[4] <= cos_c;
					end
				end
				CMD_MACC: begin
					if (ctrl.idx[4]) begin
						case (ctrl.idx[1:0])
							2'd0: bas_q[0] <= p14;
							2'd1: bas_q[2] <= p14;
							2'd2: bas_q[5] <= -p14;
							default: bas_q[7] <= -p14;
						endcase
					end else
						pos_q[ctrl.idx[1:0]] <= psat;
				end
				CMD_HOME: begin
					pos_q[0] <= start_x; pos_q[1] <= start_y; pos_q[2] <= start_z;
					head_q <= HEAD_HOME;
					elev_q <= '0;
					bas_q[0] <= '0; bas_q[1] <= '0; bas_q[2] <= -ONE14; bas_q[3] <= ONE14;
					bas_q[4] <= '0; bas_q[5] <= '0; bas_q[6] <= ONE14; bas_q[7] <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		// biased yaw sum, registered ahead of the angle update
		hv_q <= 26'(head_q) + 26'($signed(hstep_q[40:16])) + 26'sd8524800;
		case (ctrl.cmd)
			CMD_LOAD: begin
				op_q <= in_op;
				key_q <= in_key;
				vel_q <= move_speed * in_dt;
				hstep_q <= 41'(in_xo) * 41'($signed({1'b0, mouse_gain})) + 41'sd32768;
				pstep_q <= 41'(in_yo) * 41'($signed({1'b0, mouse_gain})) + 41'sd32768;
			end
			CMD_CINIT: begin
				cx_q <= 34'(CORDIC_X0);
				cyv_q <= '0;
				cz_q <= 25'(afold) <<< 8;
				flip_q <= (ang > 18'(DEG90)) || (ang < -18'(DEG90));
			end
			CMD_CITER: begin
				if (!cz_q[24]) begin
					cx_q <= cx_q - dx; cyv_q <= cyv_q + dy;
					cz_q <= cz_q - 25'($signed({1'b0, atan_deg16(ctrl.idx)}));
				end else begin
					cx_q <= cx_q + dx; cyv_q <= cyv_q - dy;
					cz_q <= cz_q + 25'($signed({1'b0, atan_deg16(ctrl.idx)}));
				end
			end
			CMD_CDONE: begin
				if (ctrl.sel) begin
					cp_q <= cos_c; sp_q <= sin_c;
				end else begin
					cy_q <= cos_c; sy_q <= sin_c;
				end
			end
			CMD_PROD: prod_q <= 49'(mfull);
			CMD_MSTEP: prod_q <= 49'(mfull);
			CMD_OUT: result <= {pos_q[0], pos_q[1], pos_q[2], bas_q[0], bas_q[1], bas_q[2],
				bas_q[3], bas_q[4], bas_q[5], bas_q[6], bas_q[7]};
			default: ;
		endcase
	end

	assign stat.op = op_q;
	assign stat.key = key_q;

	localparam int ITERS = (CORDIC_ITERATIONS < ATAN_N) ? CORDIC_ITERATIONS : ATAN_N;
	always_comb assert (ITERS <= ATAN_N);
	ap_head: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q >= -17'(DEG180)) && (head_q < 17'(DEG180))) else $error("yaw out of range");
	ap_elev: assert property (@(posedge clk) disable iff (!arst_n)
		(elev_q <= PITCH_LIM) && (elev_q >= -PITCH_LIM)) else $error("pitch out of range");
	ap_home: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.cmd == CMD_HOME |=> head_q == HEAD_HOME) else $error("home angle");
endmodule

FILE: src/ypc_ctl.sv
// Controller for the camera block: sequences load, angle update, CORDIC, products, move.
// Depends on ypc_pkg.
module ypc_ctl #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  ypc_pkg::ypc_stat_t stat,
	output ypc_pkg::ypc_ctrl_t ctrl
);
	import ypc_pkg::*;

	localparam int ITERS = (CORDIC_ITERATIONS < ATAN_N) ? CORDIC_ITERATIONS : ATAN_N;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_DEC   = 10'b0000000010,
		S_ANG   = 10'b0000000100,
		S_CINIT = 10'b0000001000,
		S_CITER = 10'b0000010000,
		S_CDONE = 10'b0000100000,
		S_PROD  = 10'b0001000000,
		S_ACC   = 10'b0010000000,
		S_OUT   = 10'b0100000000,
		S_HOLD  = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [4:0] idx_q;
	logic sel_q, bas_q;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;

	always_comb begin
		ctrl.cmd = CMD_NONE;
		ctrl.sel = sel_q;
		ctrl.idx = idx_q;
		case (state_q)
			S_IDLE: if (in_valid && in_ready) ctrl.cmd = CMD_LOAD;
			S_DEC: if (stat.op == OP_HOME) ctrl.cmd = CMD_HOME;
			S_ANG: ctrl.cmd = CMD_ANGLE;
			S_CINIT: ctrl.cmd = CMD_CINIT;
			S_CITER: ctrl.cmd = CMD_CITER;
			S_CDONE: ctrl.cmd = CMD_CDONE;
			S_PROD: ctrl.cmd = bas_q ? CMD_PROD : CMD_MSTEP;
			S_ACC: begin
				ctrl.cmd = CMD_MACC;
				ctrl.idx = {bas_q, 2'b00, idx_q[1:0]};
			end
			S_OUT: ctrl.cmd = CMD_OUT;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q <= '0;
			sel_q <= 1'b0;
			bas_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) state_q <= S_DEC;
				S_DEC: begin
					idx_q <= '0;
					sel_q <= 1'b0;
					if (stat.op == OP_TURN) begin
						bas_q <= 1'b1;
						state_q <= S_ANG;
					end else if (stat.op == OP_MOVE && !stat.key[2]) begin
						bas_q <= 1'b0;
						state_q <= S_PROD;
					end else
						state_q <= S_OUT;
				end
				S_ANG: state_q <= S_CINIT;
				S_CINIT: begin
					idx_q <= '0;
					state_q <= S_CITER;
				end
				S_CITER: begin
					if (idx_q == 5'(ITERS - 1))
						state_q <= S_CDONE;
					idx_q <= idx_q + 5'd1;
				end
				S_CDONE: begin
					idx_q <= '0;
					if (!sel_q) begin
						sel_q <= 1'b1;
						state_q <= S_CINIT;
					end else
						state_q <= S_PROD;
				end
				S_PROD: state_q <= S_ACC;
				S_ACC: begin
					if (idx_q[1:0] == (bas_q ? 2'd3 : 2'd2))
						state_q <= S_OUT;
					else
						state_q <= S_PROD;
					idx_q <= idx_q + 5'd1;
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= S_HOLD;
				end
				S_HOLD: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !in_ready) else $error("ready while busy");
	ap_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_OUT |=> out_valid) else $error("result not raised");
	ap_citer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CITER |-> idx_q < 5'(ITERS)) else $error("cordic overrun");
endmodule

FILE: src/yaw_pitch_camera_update.sv
// Top level of the fly-camera yaw/pitch block: APB registers, controller and datapath.
// Depends on ypc_pkg, ypc_if, ypc_ctl, ypc_dp.
//
// One item at a time. A move item makes three multiply-and-accumulate passes through
// the shared multiplier; a mouse item runs the single CORDIC unit on yaw then pitch,
// one micro-rotation a cycle, followed by four basis products; a home or no-move item
// uses neither. The result sits in an output register; the next item is taken once it
// has been transferred.
// Input payload bits, LSB first: operation[1:0], move_key[4:2], delta_time[20:5],
// x_offset[44:21], y_offset[68:45]. Result payload, MSB first: pos_x, pos_y, pos_z,
// front_x/y/z, right_x, right_z, up_x/y/z.
module yaw_pitch_camera_update #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	ypc_if.sink         in_ch,
	ypc_if.source       out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ypc_pkg::*;

	logic [15:0] speed_q, gain_q;
	logic signed [31:0] sx_q, sy_q, sz_q;
	logic [2:0] ridx;
	assign ridx = paddr[4:2];
	assign pready = 1'b1;

	// register write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= 16'd1280;
			gain_q <= 16'd6554;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_SPEED: speed_q <= pwdata[15:0];
				REG_GAIN: gain_q <= pwdata[15:0];
				REG_SX: sx_q <= pwdata;
				REG_SY: sy_q <= pwdata;
				REG_SZ: sz_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_SPEED: prdata = {16'd0, speed_q};
			REG_GAIN: prdata = {16'd0, gain_q};
			REG_SX: prdata = sx_q;
			REG_SY: prdata = sy_q;
			REG_SZ: prdata = sz_q;
			default: prdata = '0;
		endcase
	end

	ypc_ctrl_t ctrl;
	ypc_stat_t stat;

	ypc_ctl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.stat, .ctrl
	);

	ypc_dp #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_dp (
		.clk, .arst_n, .ctrl, .stat,
		.in_op(in_ch.data[1:0]), .in_key(in_ch.data[4:2]), .in_dt(in_ch.data[20:5]),
		.in_xo(in_ch.data[44:21]), .in_yo(in_ch.data[68:45]),
		.move_speed(speed_q), .mouse_gain(gain_q),
		.start_x(sx_q), .start_y(sy_q), .start_z(sz_q),
		.result(out_ch.data)
	);
endmodule
